@@ sv/dram_longest_row_run_finder_assert.svh @@
// Assertion macros shared by the RTL of the longest row run finder.
`ifndef DRAM_LONGEST_ROW_RUN_FINDER_ASSERT_SVH
`define DRAM_LONGEST_ROW_RUN_FINDER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and quiet during reset.
`define DLRR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dlrr assertion failed");

// Next-cycle implication, sampled on clk_i and quiet during reset.
`define DLRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dlrr assertion failed");

`endif

@@ sv/dlrr_pkg.sv @@
`default_nettype none
package dlrr_pkg;

  localparam int NUM_PAGES  = 64;
  localparam int PAGE_BYTES = 4096;

  localparam int IDX_W  = $clog2(NUM_PAGES);
  localparam int CNT_W  = $clog2(NUM_PAGES + 1);
  localparam int ADDR_W = 40;
  localparam int VA_W   = 48;
  localparam int BANK_W = 5;
  localparam int ROW_W  = 40;
  localparam int SH_W   = 6;
  localparam int LEN_W  = 7;
  localparam int CFG_W  = 48;
  localparam int CIDX_W = 3;

  localparam logic [VA_W-1:0] PAGE_STRIDE = VA_W'(PAGE_BYTES);

  // Configuration register indices.
  localparam logic [CIDX_W-1:0] REG_BANK_MASK_0 = 3'd0;
  localparam logic [CIDX_W-1:0] REG_BANK_MASK_1 = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BANK_MASK_2 = 3'd2;
  localparam logic [CIDX_W-1:0] REG_BANK_MASK_3 = 3'd3;
  localparam logic [CIDX_W-1:0] REG_BANK_MASK_4 = 3'd4;
  localparam logic [CIDX_W-1:0] REG_BANK_FN_CNT = 3'd5;
  localparam logic [CIDX_W-1:0] REG_ROW_MASK    = 3'd6;
  localparam logic [CIDX_W-1:0] REG_PAGE_BASE   = 3'd7;

  localparam logic [ADDR_W-1:0] RST_BANK_MASK_0 = 40'h2040;
  localparam logic [ADDR_W-1:0] RST_BANK_MASK_1 = 40'h44000;
  localparam logic [ADDR_W-1:0] RST_BANK_MASK_2 = 40'h88000;
  localparam logic [ADDR_W-1:0] RST_BANK_MASK_3 = 40'h110000;
  localparam logic [ADDR_W-1:0] RST_BANK_MASK_4 = 40'h220000;
  localparam logic [2:0]        RST_BANK_FN_CNT = 3'd5;
  localparam logic [ADDR_W-1:0] RST_ROW_MASK    = 40'hffffc0000;
  localparam logic [SH_W-1:0]   RST_ROW_SHIFT   = 6'd18;

  localparam logic [ADDR_W-1:0] PAGE_KEEP = 40'hffffff_f000;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [ROW_W-1:0]  row;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  // Position of the lowest set bit; zero for an empty mask.
  function automatic logic [SH_W-1:0] lowest_set(input logic [ADDR_W-1:0] m);
    logic [SH_W-1:0] p;
    p = '0;
    for (int k = ADDR_W - 1; k >= 0; k--) begin
      if (m[k]) begin
        p = SH_W'(k);
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

@@ sv/dlrr_if.sv @@
`default_nettype none
interface dlrr_in_if import dlrr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] paddr;
  modport source (output valid, output paddr, input ready);
  modport sink (input valid, input paddr, output ready);
endinterface

interface dlrr_out_if import dlrr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VA_W-1:0]  page_addr;
  logic [LEN_W-1:0] run_length;
  logic             last_page;
  modport source (output valid, output page_addr, output run_length, output last_page,
                  input ready);
  modport sink (input valid, input page_addr, input run_length, input last_page,
                output ready);
endinterface
`default_nettype wire

@@ sv/dram_longest_row_run_finder.sv @@
// Channel   Direction  Payload
// in_i      sink       paddr[39:0]
// out_o     source     page_addr[47:0], run_length[6:0], last_page
// cfg       write      cfg_we_i, cfg_idx_i[2:0], cfg_data_i[47:0]
//
// Each address is inserted into the sorted entry RAM as it arrives: in_i stays busy
// until the new page has moved past every stored entry that sorts after it (one RAM
// step per cycle). After the last page of a batch the RAM is scanned in address order,
// then each page of the best run is read, loaded into the output register and held on
// out_o until taken.
// Reset clears control and loads the configuration defaults; the entry RAM needs no clearing.
// in_i is ready only between transactions; out_o holds its result until taken.
`default_nettype none
`include "dram_longest_row_run_finder_assert.svh"
module dram_longest_row_run_finder
  import dlrr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CIDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  dlrr_in_if.sink                in_i,
  dlrr_out_if.source             out_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;
  localparam logic [2:0] S_EMIT_WT = 3'd6;

  logic [ADDR_W-1:0] bmask_q [BANK_W];
  logic [2:0]        bcnt_q;
  logic [ADDR_W-1:0] rmask_q;
  logic [SH_W-1:0]   rshift_q;
  logic [VA_W-1:0]   base_q;

  logic [2:0]       state_q, state_d;
  entry_t           t_q, t_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             rvalid_q;
  logic [IDX_W-1:0] pos_q, pos_d;
  entry_t           prev_q, prev_d;
  logic [IDX_W-1:0] cur_start_q, cur_start_d, best_start_q, best_start_d;
  logic [CNT_W-1:0] cur_len_q, cur_len_d, best_len_q, best_len_d;
  logic [IDX_W-1:0] emit_k_q, emit_k_d;

  logic             out_valid_q, out_valid_d;
  logic [VA_W-1:0]  page_addr_q, page_addr_d;
  logic [LEN_W-1:0] run_len_q, run_len_d;
  logic             last_q, last_d;

  logic [$bits(entry_t)-1:0] mem_q [NUM_PAGES];
  entry_t           rdata_q;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata;

  logic [ADDR_W-1:0] addr;
  entry_t            new_e;
  logic              less, cont;
  logic [ROW_W:0]    prev_inc;
  logic [CNT_W-1:0]  len_inc;

  // Bank and row of the incoming page under the configuration now in force.
  always_comb begin
    addr = in_i.paddr & PAGE_KEEP;
    new_e.bank = '0;
    for (int b = 0; b < BANK_W; b++) begin
      if (bcnt_q > 3'(b)) begin
        new_e.bank[b] = ^(addr & bmask_q[b]);
      end
    end
    new_e.row = (addr & rmask_q) >> rshift_q;
    new_e.idx = load_cnt_q[IDX_W-1:0];
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.page_addr  = page_addr_q;
  assign out_o.run_length = run_len_q;
  assign out_o.last_page  = last_q;

  assign less = (t_q.bank < rdata_q.bank) ||
                ((t_q.bank == rdata_q.bank) && (t_q.row < rdata_q.row));
  assign prev_inc = {1'b0, prev_q.row} + (ROW_W+1)'(1);
  assign cont = (rdata_q.bank == prev_q.bank) &&
                ((rdata_q.row == prev_q.row) || ({1'b0, rdata_q.row} == prev_inc));
  assign len_inc = cur_len_q + CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    t_d          = t_q;
    j_d          = j_q;
    load_cnt_d   = load_cnt_q;
    rd_idx_d     = rd_idx_q;
    pos_d        = pos_q;
    prev_d       = prev_q;
    cur_start_d  = cur_start_q;
    cur_len_d    = cur_len_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    emit_k_d     = emit_k_q;
    out_valid_d  = out_valid_q;
    page_addr_d  = page_addr_q;
    run_len_d    = run_len_q;
    last_d       = last_q;
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = t_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          t_d     = new_e;
          j_d     = load_cnt_q[IDX_W-1:0];
          state_d = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (j_q == '0) begin
          we         = 1'b1;
          waddr      = '0;
          load_cnt_d = load_cnt_q + CNT_W'(1);
          state_d    = (load_cnt_d == CNT_W'(NUM_PAGES)) ? S_SCAN : S_IDLE;
          rd_idx_d   = '0;
          pos_d      = '0;
        end else begin
          re      = 1'b1;
          raddr   = j_q - IDX_W'(1);
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        // The write to slot j and the read of slot j-2 never share an address.
        we    = 1'b1;
        waddr = j_q;
        if (less) begin
          wdata = rdata_q;
          j_d   = j_q - IDX_W'(1);
          if (j_d == '0) begin
            state_d = S_INS_RD;
          end else begin
            re    = 1'b1;
            raddr = j_d - IDX_W'(1);
          end
        end else begin
          load_cnt_d = load_cnt_q + CNT_W'(1);
          state_d    = (load_cnt_d == CNT_W'(NUM_PAGES)) ? S_SCAN : S_IDLE;
          rd_idx_d   = '0;
          pos_d      = '0;
        end
      end
      S_SCAN: begin
        if (rd_idx_q < CNT_W'(NUM_PAGES)) begin
          re       = 1'b1;
          raddr    = rd_idx_q[IDX_W-1:0];
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        if (rvalid_q) begin
          prev_d = rdata_q;
          pos_d  = pos_q + IDX_W'(1);
          if (pos_q == '0) begin
            cur_start_d  = '0;
            cur_len_d    = CNT_W'(1);
            best_start_d = '0;
            best_len_d   = '0;
          end else if (cont) begin
            cur_len_d = len_inc;
          end else begin
            if (cur_len_q > best_len_q) begin
              best_len_d   = cur_len_q;
              best_start_d = cur_start_q;
            end
            cur_len_d   = CNT_W'(1);
            cur_start_d = pos_q;
          end
          if (pos_q == IDX_W'(NUM_PAGES - 1)) begin
            // Close the run that reaches the end of the sorted list.
            if (cur_len_d > best_len_d) begin
              best_len_d   = cur_len_d;
              best_start_d = cur_start_d;
            end
            emit_k_d = '0;
            state_d  = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        re      = 1'b1;
        raddr   = best_start_q + emit_k_q;
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        page_addr_d = base_q + ({{(VA_W-IDX_W){1'b0}}, rdata_q.idx} * PAGE_STRIDE);
        run_len_d   = LEN_W'(best_len_q);
        last_d      = ({1'b0, emit_k_q} + CNT_W'(1)) == best_len_q;
        out_valid_d = 1'b1;
        state_d     = S_EMIT_WT;
      end
      S_EMIT_WT: begin
        if (out_o.ready) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            load_cnt_d = '0;
            state_d    = S_IDLE;
          end else begin
            emit_k_d = emit_k_q + IDX_W'(1);
            state_d  = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      load_cnt_q   <= '0;
      rd_idx_q     <= '0;
      rvalid_q     <= 1'b0;
      pos_q        <= '0;
      cur_start_q  <= '0;
      cur_len_q    <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
      emit_k_q     <= '0;
      out_valid_q  <= 1'b0;
      bmask_q[0]   <= RST_BANK_MASK_0;
      bmask_q[1]   <= RST_BANK_MASK_1;
      bmask_q[2]   <= RST_BANK_MASK_2;
      bmask_q[3]   <= RST_BANK_MASK_3;
      bmask_q[4]   <= RST_BANK_MASK_4;
      bcnt_q       <= RST_BANK_FN_CNT;
      rmask_q      <= RST_ROW_MASK;
      rshift_q     <= RST_ROW_SHIFT;
      base_q       <= '0;
    end else begin
      state_q      <= state_d;
      load_cnt_q   <= load_cnt_d;
      rd_idx_q     <= rd_idx_d;
      rvalid_q     <= re && (state_q == S_SCAN);
      pos_q        <= pos_d;
      cur_start_q  <= cur_start_d;
      cur_len_q    <= cur_len_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
      emit_k_q     <= emit_k_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BANK_MASK_0: bmask_q[0] <= cfg_data_i[ADDR_W-1:0];
          REG_BANK_MASK_1: bmask_q[1] <= cfg_data_i[ADDR_W-1:0];
          REG_BANK_MASK_2: bmask_q[2] <= cfg_data_i[ADDR_W-1:0];
          REG_BANK_MASK_3: bmask_q[3] <= cfg_data_i[ADDR_W-1:0];
          REG_BANK_MASK_4: bmask_q[4] <= cfg_data_i[ADDR_W-1:0];
          REG_BANK_FN_CNT: bcnt_q     <= cfg_data_i[2:0];
          REG_ROW_MASK: begin
            rmask_q  <= cfg_data_i[ADDR_W-1:0];
            rshift_q <= lowest_set(cfg_data_i[ADDR_W-1:0]);
          end
          REG_PAGE_BASE:   base_q     <= cfg_data_i[VA_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q         <= t_d;
    j_q         <= j_d;
    prev_q      <= prev_d;
    page_addr_q <= page_addr_d;
    run_len_q   <= run_len_d;
    last_q      <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  `DLRR_ASSERT_IMPL(a_out_only_in_emit, out_valid_q, state_q == S_EMIT_WT)
  `DLRR_ASSERT_IMPL(a_ready_room, in_i.ready, load_cnt_q < CNT_W'(NUM_PAGES))
  `DLRR_ASSERT_NEXT(a_accept_inserts, in_i.valid && in_i.ready, state_q == S_INS_RD)
  `DLRR_ASSERT_IMPL(a_last_at_len, out_valid_q && last_q, ({1'b0, emit_k_q} + CNT_W'(1)) == best_len_q)

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none
module tb;
  import dlrr_pkg::*;

  typedef struct packed {
    logic [VA_W-1:0]  page_addr;
    logic [LEN_W-1:0] run_length;
    logic             last_page;
  } page_result_t;

  typedef struct {
    logic [BANK_W-1:0] bank;
    logic [ROW_W-1:0]  row;
    int unsigned       idx;
  } page_key_t;

  logic clk_i;
  logic rst_ni;
  logic              cfg_we_i;
  logic [CIDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;

  dlrr_in_if  in_ch ();
  dlrr_out_if out_ch ();

  dram_longest_row_run_finder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  // Shadow copy of the configuration registers.
  logic [ADDR_W-1:0] bank_masks[BANK_W];
  logic [2:0]        fn_count;
  logic [ADDR_W-1:0] row_bits;
  logic [VA_W-1:0]   va_base;

  page_key_t    batch_keys[NUM_PAGES];
  int unsigned  loaded;
  page_result_t run_pages_q[$];
  int unsigned  errors;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [ROW_W-1:0] row_from(input logic [ADDR_W-1:0] a);
    int sh;
    sh = 0;
    if (row_bits == '0) return '0;
    while (!row_bits[sh]) sh++;
    return (a & row_bits) >> sh;
  endfunction

  function automatic logic [BANK_W-1:0] bank_from(input logic [ADDR_W-1:0] a);
    logic [BANK_W-1:0] b;
    int n;
    b = '0;
    n = (fn_count > 5) ? 5 : fn_count;
    for (int i = 0; i < n; i++) b[i] = ^(a & bank_masks[i]);
    return b;
  endfunction

  // Loads one page key and, on the last page of a batch, predicts the run.
  task automatic record_page(input logic [ADDR_W-1:0] raw);
    logic [ADDR_W-1:0] a;
    page_key_t s[NUM_PAGES];
    page_key_t t;
    int j, cur_start, cur_len, best_start, best_len;
    page_result_t r;
    a = raw & PAGE_KEEP;
    batch_keys[loaded].bank = bank_from(a);
    batch_keys[loaded].row  = row_from(a);
    batch_keys[loaded].idx  = loaded;
    loaded++;
    if (loaded < NUM_PAGES) return;
    s = batch_keys;
    for (int i = 1; i < NUM_PAGES; i++) begin
      t = s[i];
      j = i;
      while (j > 0 && (t.bank < s[j-1].bank ||
                       (t.bank == s[j-1].bank && t.row < s[j-1].row))) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = t;
    end
    best_start = 0;
    best_len = 0;
    cur_start = 0;
    cur_len = 1;
    for (int i = 1; i < NUM_PAGES; i++) begin
      if (s[i].bank == s[cur_start].bank &&
          ({1'b0, s[i].row} == {1'b0, s[i-1].row} ||
           {1'b0, s[i].row} == {1'b0, s[i-1].row} + 41'd1)) begin
        cur_len++;
      end else begin
        if (cur_len > best_len) begin
          best_len = cur_len;
          best_start = cur_start;
        end
        cur_len = 1;
        cur_start = i;
      end
    end
    if (cur_len > best_len) begin
      best_len = cur_len;
      best_start = cur_start;
    end
    for (int i = 0; i < best_len; i++) begin
      r.page_addr  = va_base + VA_W'(s[best_start + i].idx) * PAGE_STRIDE;
      r.run_length = LEN_W'(best_len);
      r.last_page  = (i + 1 == best_len);
      run_pages_q.push_back(r);
    end
    loaded = 0;
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= REG_BANK_MASK_4) bank_masks[idx] = data[ADDR_W-1:0];
    else if (idx == REG_BANK_FN_CNT) fn_count = data[2:0];
    else if (idx == REG_ROW_MASK) row_bits = data[ADDR_W-1:0];
    else va_base = data[VA_W-1:0];
  endtask

  task automatic send_addr(input logic [ADDR_W-1:0] a);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.paddr <= a;
    do @(posedge clk_i); while (!in_ch.ready);
    record_page(a);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (run_pages_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr40();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Mostly pages clustered around one row so that long runs form, with noise.
  task automatic send_random_batch;
    logic [ADDR_W-1:0] base, a;
    int sh;
    sh = 0;
    if (row_bits != '0) while (!row_bits[sh]) sh++;
    base = rand_addr40();
    for (int i = 0; i < NUM_PAGES; i++) begin
      if ($urandom_range(0, 9) < 7)
        a = base + (ADDR_W'($urandom_range(0, 4)) << sh) + ADDR_W'($urandom_range(0, 4095));
      else
        a = rand_addr40();
      send_addr(a);
    end
  endtask

  task automatic test_reset_defaults;
    logic [ADDR_W-1:0] pick[20];
    pick = '{40'h0, 40'hff_ffff_ffff, 40'h0_0000_0fff, 40'h0_0000_1000, 40'h80_0000_0000,
             40'h0_0000_2040, 40'h0_0004_4000, 40'h0_0008_8000, 40'h0_0011_0000,
             40'h0_0022_0000, 40'h0_0004_0000, 40'h0_0008_0000, 40'h0_000c_0000,
             40'hf_fffc_0000, 40'h55_5555_5555, 40'haa_aaaa_aaaa, 40'h0_0010_0000,
             40'h0_0014_0000, 40'h0_0018_0000, 40'h0_001c_0000};
    foreach (pick[i]) send_addr(pick[i]);
    // Pages two to a row in one bank, with the rows far apart.
    for (int i = 20; i < NUM_PAGES; i++) send_addr(ADDR_W'(i / 2) << 24);
    drain();
  endtask

  // An empty row mask, a bank count above five, one empty bank mask and a page base
  // that makes the page addresses wrap.
  task automatic test_odd_config;
    write_reg(REG_BANK_MASK_0, '0);
    for (int i = 1; i < 5; i++) write_reg(REG_BANK_MASK_0 + CIDX_W'(i), CFG_W'(rand_addr40()));
    write_reg(REG_BANK_FN_CNT, 48'd7);
    write_reg(REG_ROW_MASK, '0);
    write_reg(REG_PAGE_BASE, 48'hffff_ffff_ffff);
    send_random_batch();
    drain();
  endtask

  // Result side: random back-pressure, and every transaction checked in order.
  initial begin
    int gap;
    page_result_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      if (run_pages_q.size() == 0) begin
        $display("%0t: expected no result, actual page_addr=%h", $realtime,
                 out_ch.page_addr);
        errors++;
      end else begin
        want = run_pages_q.pop_front();
        if (out_ch.page_addr !== want.page_addr) begin
          $display("%0t: page_addr expected %h actual %h", $realtime, want.page_addr,
                   out_ch.page_addr);
          errors++;
        end
        if (out_ch.run_length !== want.run_length) begin
          $display("%0t: run_length expected %0d actual %0d", $realtime, want.run_length,
                   out_ch.run_length);
          errors++;
        end
        if (out_ch.last_page !== want.last_page) begin
          $display("%0t: last_page expected %b actual %b", $realtime, want.last_page,
                   out_ch.last_page);
          errors++;
        end
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.paddr = '0;
    errors = 0;
    loaded = 0;
    bank_masks[0] = RST_BANK_MASK_0;
    bank_masks[1] = RST_BANK_MASK_1;
    bank_masks[2] = RST_BANK_MASK_2;
    bank_masks[3] = RST_BANK_MASK_3;
    bank_masks[4] = RST_BANK_MASK_4;
    fn_count = RST_BANK_FN_CNT;
    row_bits = RST_ROW_MASK;
    va_base = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_odd_config();
    if (errors == 0 && run_pages_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
